@@ rtl/sbcm_pkg.sv @@
package sbcm_pkg;

	localparam int BIN_FRACTION_BITS = 18;
	localparam int LOG_TABLE_BITS = 8;
	localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
	localparam logic [15:0] LOG10_OF_2_Q16 = 16'd19728;

	localparam logic [1:0] CMD_MAP = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [1:0] REG_LEVEL_FLOOR = 2'd0;
	localparam logic [1:0] REG_LEVEL_CEIL = 2'd1;
	localparam logic [1:0] REG_GLOW_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_LOG2_WINDOW = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_SQ_RE,
		OP_SQ_IM,
		OP_NORM,
		OP_LOG,
		OP_MUL,
		OP_LEVEL,
		OP_DIV_RED,
		OP_TAKE_RED,
		OP_DIV_INT,
		OP_TAKE_INT,
		OP_DIV_FIN,
		OP_TAKE_FIN,
		OP_DIV_GLOW
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   take_glow;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       norm_done;
		logic       div_done;
		logic       span_pos;
		logic       peak_nz;
		logic       glow_on;
	} dp_status_t;

	typedef logic [15:0] log_tab_t [LOG_TABLE_SIZE];

	function automatic log_tab_t gen_log_tab();
		log_tab_t    t;
		logic [63:0] x;
		logic [15:0] r;
		for (int m = 0; m < LOG_TABLE_SIZE; m++) begin
			x = 64'(LOG_TABLE_SIZE + m) << (30 - LOG_TABLE_BITS);
			r = '0;
			for (int k = 0; k < 16; k++) begin
				x = (x * x) >> 30;
				r = {r[14:0], 1'b0};
				if (x >= 64'h8000_0000) begin
					x = x >> 1;
					r[0] = 1'b1;
				end
			end
			t[m] = r;
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = gen_log_tab();

endpackage

@@ rtl/spectrogram_bin_colour_map_unit.sv @@
// Maps FFT bins to spectrogram colours one transaction at a time. A map
// transaction squares the real, then the imaginary part, runs a
// one-bit-per-cycle normalizing shift of the 64-bit power, table lookup
// and scaling, then up to two passes of the shared 32-step restoring
// divider. A finish transaction takes up to two divider passes, clear and
// unused commands none. A result waits in the output register while the
// next input transaction is taken. Configuration writes are taken every cycle.
module spectrogram_bin_colour_map_unit
	import sbcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] bin_real,
	input  logic [31:0] bin_imag,
	input  logic [7:0]  stored_red,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] peak_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dp_cmd_t    ctl;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	sbcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctl       (ctl)
	);

	sbcm_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.bin_real   (bin_real),
		.bin_imag   (bin_imag),
		.stored_red (stored_red),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.peak_level (peak_level)
	);

endmodule

@@ rtl/sbcm_div.sv @@
module sbcm_div
	import sbcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [16:0] den,
	output logic        done,
	output logic [31:0] quo
);

	logic [17:0] rem_q;
	logic [31:0] quo_q;
	logic [16:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;
	logic        fits;

	assign trial = {rem_q[16:0], quo_q[31]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ rtl/sbcm_datapath.sv @@
module sbcm_datapath
	import sbcm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  dp_cmd_t      ctl,
	output dp_status_t   status,
	input  logic         cfg_valid,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic [1:0]   cmd,
	input  logic [31:0]  bin_real,
	input  logic [31:0]  bin_imag,
	input  logic [7:0]   stored_red,
	output logic [7:0]   red,
	output logic [7:0]   green,
	output logic [7:0]   blue,
	output logic [15:0]  peak_level
);

	logic [15:0] floor_q;
	logic [15:0] ceil_q;
	logic [7:0]  thr_q;
	logic [4:0]  lw_q;
	logic [15:0] peak_q;

	logic [1:0]  cmd_q;
	logic [31:0] re_q;
	logic [31:0] im_q;
	logic [7:0]  sr_q;
	logic [63:0] sum_q;
	logic [5:0]  e_q;
	logic        zero_q;
	logic [24:0] v_q;
	logic [40:0] p_q;
	logic [15:0] n_q;
	logic [16:0] span_q;
	logic [7:0]  red_q;
	logic [7:0]  glow_q;
	logic [7:0]  red_out_q;
	logic [7:0]  glow_out_q;
	logic [15:0] peak_out_q;

	logic [31:0] ar;
	logic [31:0] ai;
	logic [LOG_TABLE_BITS-1:0] tab_idx;
	logic signed [15:0] lvl;
	logic signed [15:0] c_lo;
	logic signed [15:0] c_cl;
	logic [16:0] thr255;
	logic [15:0] inten;

	logic        div_start;
	logic [31:0] div_num;
	logic [16:0] div_den;
	logic        div_done;
	logic [31:0] div_quo;

	assign ar = re_q[31] ? 32'(-re_q) : re_q;
	assign ai = im_q[31] ? 32'(-im_q) : im_q;
	assign tab_idx = sum_q[62 -: LOG_TABLE_BITS];
	assign lvl = zero_q ? 16'sh8000 : $signed(p_q[40:25]);
	assign c_lo = (lvl < $signed(floor_q)) ? $signed(floor_q) : lvl;
	assign c_cl = (c_lo > $signed(ceil_q)) ? $signed(ceil_q) : c_lo;
	assign thr255 = {1'b0, thr_q, 8'h00} - 17'(thr_q);
	assign inten = (|div_quo[31:16]) ? 16'hFFFF : div_quo[15:0];

	always_comb begin
		div_start = 1'b1;
		div_num = '0;
		div_den = 17'd1;
		case (ctl.op)
			OP_DIV_RED: begin
				div_num = 32'({n_q, 8'h00}) - 32'(n_q);
				div_den = span_q;
			end
			OP_DIV_INT: begin
				div_num = {n_q, 16'h0000};
				div_den = span_q;
			end
			OP_DIV_FIN: begin
				div_num = {8'h00, sr_q, 16'h0000};
				div_den = {1'b0, peak_q};
			end
			OP_DIV_GLOW: begin
				div_num = 32'({red_q, 8'h00}) - 32'(thr255);
				div_den = 17'(9'd256 - 9'(thr_q));
			end
			default: div_start = 1'b0;
		endcase
	end

	sbcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 16'hF800;
			ceil_q <= 16'hFB00;
			thr_q <= 8'd128;
			lw_q <= 5'd12;
			peak_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_LEVEL_FLOOR:    floor_q <= cfg_data;
					REG_LEVEL_CEIL:     ceil_q <= cfg_data;
					REG_GLOW_THRESHOLD: thr_q <= cfg_data[7:0];
					REG_LOG2_WINDOW:    lw_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (ctl.op == OP_CLEAR) begin
				peak_q <= '0;
			end else if (ctl.op == OP_TAKE_INT && inten > peak_q) begin
				peak_q <= inten;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				cmd_q <= cmd;
				re_q <= bin_real;
				im_q <= bin_imag;
				sr_q <= stored_red;
				red_q <= '0;
				glow_q <= '0;
			end
			OP_SQ_RE: begin
				sum_q <= ar * ar;
				e_q <= 6'd63;
			end
			OP_SQ_IM: sum_q <= sum_q + ai * ai;
			OP_NORM: begin
				sum_q <= {sum_q[62:0], 1'b0};
				e_q <= e_q - 6'd1;
			end
			OP_LOG: begin
				zero_q <= (sum_q == '0);
				v_q <= 25'({e_q, 16'h0000}) + 25'(LOG_TAB[tab_idx])
					- ((25'(BIN_FRACTION_BITS) + 25'(lw_q)) << 17);
			end
			OP_MUL: p_q <= 41'($signed(v_q)) * 41'($signed({1'b0, LOG10_OF_2_Q16}));
			OP_LEVEL: begin
				n_q <= 16'(17'($signed(c_cl)) - 17'($signed(floor_q)));
				span_q <= 17'($signed(ceil_q)) - 17'($signed(floor_q));
			end
			OP_TAKE_RED: red_q <= div_quo[7:0];
			OP_TAKE_FIN: red_q <= (|div_quo[31:8]) ? 8'hFF : div_quo[7:0];
			default: ;
		endcase
		if (ctl.take_glow) begin
			glow_q <= div_quo[7:0];
		end
		if (ctl.load_out) begin
			red_out_q <= red_q;
			glow_out_q <= glow_q;
			peak_out_q <= peak_q;
		end
	end

	always_comb begin
		status.cmd = cmd_q;
		status.norm_done = sum_q[63] || (sum_q == '0);
		status.div_done = div_done;
		status.span_pos = !span_q[16] && (span_q != '0);
		status.peak_nz = (peak_q != '0);
		status.glow_on = {1'b0, red_q, 8'h00} > thr255;
	end

	assign red = red_out_q;
	assign green = glow_out_q;
	assign blue = glow_out_q;
	assign peak_level = peak_out_q;

endmodule

@@ rtl/sbcm_ctrl.sv @@
module sbcm_ctrl
	import sbcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SQ_RE,
		S_SQ_IM,
		S_NORM,
		S_LOG,
		S_MUL,
		S_LEVEL,
		S_RED_DIV,
		S_RED_WAIT,
		S_INT_DIV,
		S_INT_WAIT,
		S_FIN_WAIT,
		S_GLOW_CHK,
		S_GLOW_WAIT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_load;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		ctl.op = OP_NONE;
		ctl.take_glow = 1'b0;
		ctl.load_out = out_load;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.op = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (status.cmd)
					CMD_MAP: state_d = S_SQ_RE;
					CMD_CLEAR: begin
						ctl.op = OP_CLEAR;
						state_d = S_DONE;
					end
					CMD_FINISH: begin
						if (status.peak_nz) begin
							ctl.op = OP_DIV_FIN;
							state_d = S_FIN_WAIT;
						end else begin
							state_d = S_GLOW_CHK;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SQ_RE: begin
				ctl.op = OP_SQ_RE;
				state_d = S_SQ_IM;
			end
			S_SQ_IM: begin
				ctl.op = OP_SQ_IM;
				state_d = S_NORM;
			end
			S_NORM: begin
				if (status.norm_done) begin
					state_d = S_LOG;
				end else begin
					ctl.op = OP_NORM;
				end
			end
			S_LOG: begin
				ctl.op = OP_LOG;
				state_d = S_MUL;
			end
			S_MUL: begin
				ctl.op = OP_MUL;
				state_d = S_LEVEL;
			end
			S_LEVEL: begin
				ctl.op = OP_LEVEL;
				state_d = S_RED_DIV;
			end
			S_RED_DIV: begin
				if (status.span_pos) begin
					ctl.op = OP_DIV_RED;
					state_d = S_RED_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RED_WAIT: begin
				if (status.div_done) begin
					ctl.op = OP_TAKE_RED;
					state_d = S_INT_DIV;
				end
			end
			S_INT_DIV: begin
				ctl.op = OP_DIV_INT;
				state_d = S_INT_WAIT;
			end
			S_INT_WAIT: begin
				if (status.div_done) begin
					ctl.op = OP_TAKE_INT;
					state_d = S_DONE;
				end
			end
			S_FIN_WAIT: begin
				if (status.div_done) begin
					ctl.op = OP_TAKE_FIN;
					state_d = S_GLOW_CHK;
				end
			end
			S_GLOW_CHK: begin
				if (status.glow_on) begin
					ctl.op = OP_DIV_GLOW;
					state_d = S_GLOW_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_GLOW_WAIT: begin
				if (status.div_done) begin
					ctl.take_glow = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ sim/tb_spectrogram_bin_colour_map_unit.sv @@
`timescale 1ns / 100ps

module tb_spectrogram_bin_colour_map_unit;
	import sbcm_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] peak_level;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_MAP;
	logic [31:0] bin_real = '0;
	logic [31:0] bin_imag = '0;
	logic [7:0]  stored_red = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] peak_level;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_LEVEL_FLOOR;
	logic [15:0] cfg_data = '0;

	// predictor state
	logic signed [15:0] floor_lvl;
	logic signed [15:0] ceil_lvl;
	logic [7:0]         glow_thr;
	logic [4:0]         win_log2;
	logic [15:0]        peak_q16;
	logic [15:0]        frac_log2_tab [256];

	pixel_t pixel_q [$];
	int     mismatches = 0;
	int     stall_cycles = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     hold_len = 0;
	int     hold_left = 0;

	spectrogram_bin_colour_map_unit uut (.*);

	always #2 clk = ~clk;

	initial begin
		logic [63:0] x;
		logic [15:0] r;
		for (int m = 0; m < 256; m++) begin
			x = 64'(256 + m) << 22;
			r = '0;
			for (int k = 0; k < 16; k++) begin
				x = (x * x) >> 30;
				r = r << 1;
				if (x[63:31] != '0) begin
					x = x >> 1;
					r = r | 16'd1;
				end
			end
			frac_log2_tab[m] = r;
		end
	end

	function automatic int bin_level(logic [31:0] re, logic [31:0] im);
		logic [63:0] ar;
		logic [63:0] ai;
		logic [63:0] pwr;
		int          e;
		int          m;
		longint      v;
		longint      q;
		ar = re[31] ? 64'(-longint'($signed(re))) : 64'(re);
		ai = im[31] ? 64'(-longint'($signed(im))) : 64'(im);
		pwr = ar * ar + ai * ai;
		e = 0;
		if (pwr == 0)
			return -32768;
		for (int b = 0; b < 64; b++)
			if (pwr[b])
				e = b;
		if (e >= 8)
			m = int'((pwr >> (e - 8)) & 64'hFF);
		else
			m = int'((pwr << (8 - e)) & 64'hFF);
		v = longint'(e) * 65536 + longint'(frac_log2_tab[m])
			- longint'(18 + int'(win_log2)) * 131072;
		q = (v * 19728) >>> 25;
		if (q < -32768)
			q = -32768;
		if (q > 32767)
			q = 32767;
		return int'(q);
	endfunction

	function automatic pixel_t colour_pixel(logic [1:0] c, logic [31:0] re, logic [31:0] im,
			logic [7:0] sr);
		pixel_t p;
		int     lvl;
		int     span;
		int     n;
		int     rv;
		longint inten;
		p = '0;
		rv = 0;
		if (c == CMD_MAP) begin
			lvl = bin_level(re, im);
			span = int'(ceil_lvl) - int'(floor_lvl);
			if (lvl < int'(floor_lvl))
				lvl = int'(floor_lvl);
			if (lvl > int'(ceil_lvl))
				lvl = int'(ceil_lvl);
			if (span > 0) begin
				n = lvl - int'(floor_lvl);
				inten = longint'(n) * 65536 / span;
				p.red = 8'(n * 255 / span);
				if (inten > 65535)
					inten = 65535;
				if (inten > longint'(peak_q16))
					peak_q16 = 16'(inten);
			end
		end else if (c == CMD_CLEAR) begin
			peak_q16 = '0;
		end else if (c == CMD_FINISH) begin
			if (peak_q16 != 0) begin
				rv = int'(sr) * 65536 / int'(peak_q16);
				if (rv > 255)
					rv = 255;
			end
			p.red = 8'(rv);
			if (256 * rv > 255 * int'(glow_thr)) begin
				p.green = 8'((256 * rv - 255 * int'(glow_thr)) / (256 - int'(glow_thr)));
				p.blue = p.green;
			end
		end
		p.peak_level = peak_q16;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			floor_lvl = -16'sd2048;
			ceil_lvl = -16'sd1280;
			glow_thr = 8'd128;
			win_log2 = 5'd12;
			peak_q16 = '0;
		end else begin
			stall_cycles = stall_cycles + 1;
			if (cfg_valid && cfg_ready) begin
				stall_cycles = 0;
				case (cfg_index)
				REG_LEVEL_FLOOR: floor_lvl = cfg_data;
				REG_LEVEL_CEIL: ceil_lvl = cfg_data;
				REG_GLOW_THRESHOLD: glow_thr = cfg_data[7:0];
				REG_LOG2_WINDOW: win_log2 = cfg_data[4:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				stall_cycles = 0;
				pixel_q.insert(pixel_q.size(),
					colour_pixel(cmd, bin_real, bin_imag, stored_red));
			end
			if (out_valid && out_ready) begin
				stall_cycles = 0;
				got = '{red, green, blue, peak_level};
				if (pixel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = pixel_q.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
							got.blue !== want.blue || got.peak_level !== want.peak_level) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", stall_cycles);
				$display("tb_spectrogram_bin_colour_map_unit NOT OK");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_len > 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_bin(logic [1:0] c, logic [31:0] re, logic [31:0] im, logic [7:0] sr);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		cmd = c;
		bin_real = re;
		bin_imag = im;
		stored_red = sr;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		in_valid = 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_part();
		logic [31:0] v;
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		v = $urandom >> $urandom_range(0, 31);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic logic [1:0] rand_cmd();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return CMD_MAP;
		if (k < 90)
			return CMD_FINISH;
		if (k < 95)
			return CMD_CLEAR;
		return CMD_UNUSED;
	endfunction

	task automatic test_directed();
		send_bin(CMD_MAP, '0, '0, 8'hFF);
		send_bin(CMD_FINISH, $urandom, $urandom, 8'd200);
		send_bin(CMD_MAP, 32'h8000_0000, 32'h8000_0000, '0);
		send_bin(CMD_MAP, 32'h7FFF_FFFF, 32'h0000_0000, '0);
		send_bin(CMD_MAP, 32'h0000_0001, 32'hFFFF_FFFF, '0);
		send_bin(CMD_MAP, 32'h0004_0000, 32'h0000_0000, '0);
		send_bin(CMD_MAP, 32'h0000_0000, 32'h0000_4000, '0);
		send_bin(CMD_FINISH, '0, '0, 8'd0);
		send_bin(CMD_FINISH, '0, '0, 8'd1);
		send_bin(CMD_FINISH, '0, '0, 8'd128);
		send_bin(CMD_FINISH, '0, '0, 8'd255);
		send_bin(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_bin(CMD_FINISH, '0, '0, 8'd77);
		send_bin(CMD_UNUSED, 32'h1234_5678, 32'h8765_4321, 8'h55);
		send_bin(CMD_MAP, 32'h0001_0000, 32'hFFFF_0000, '0);
		send_bin(CMD_FINISH, '0, '0, 8'd3);
		send_bin(CMD_UNUSED, '0, '0, '0);
	endtask

	task automatic test_config_extremes();
		logic [15:0] thr_set [3] = '{16'd0, 16'd255, 16'hFF7F};
		logic [15:0] win_set [5] = '{16'd0, 16'd1, 16'd16, 16'd31, 16'hFFEC};
		write_reg(REG_LEVEL_FLOOR, 16'h8000);
		write_reg(REG_LEVEL_CEIL, 16'h7FFF);
		foreach (win_set[i]) begin
			write_reg(REG_LOG2_WINDOW, win_set[i]);
			send_bin(CMD_MAP, 32'h7FFF_FFFF, 32'h8000_0000, '0);
			send_bin(CMD_MAP, 32'h0000_0001, '0, '0);
			send_bin(CMD_MAP, rand_part(), rand_part(), '0);
		end
		foreach (thr_set[i]) begin
			write_reg(REG_GLOW_THRESHOLD, thr_set[i]);
			send_bin(CMD_FINISH, '0, '0, 8'd255);
			send_bin(CMD_FINISH, '0, '0, 8'd1);
			send_bin(CMD_FINISH, '0, '0, 8'($urandom));
		end
		write_reg(REG_LEVEL_CEIL, 16'h8000);
		send_bin(CMD_CLEAR, '0, '0, '0);
		send_bin(CMD_MAP, 32'h7FFF_FFFF, '0, '0);
		write_reg(REG_LEVEL_FLOOR, 16'h0100);
		write_reg(REG_LEVEL_CEIL, 16'h0100);
		send_bin(CMD_MAP, 32'h7FFF_FFFF, '0, '0);
		send_bin(CMD_FINISH, '0, '0, 8'd9);
	endtask

	task automatic test_random(int count);
		int lo;
		write_reg(REG_LOG2_WINDOW, 16'($urandom_range(1, 16)));
		lo = $urandom_range(0, 4000) - 4000;
		write_reg(REG_LEVEL_FLOOR, 16'(lo));
		write_reg(REG_LEVEL_CEIL, 16'(lo + $urandom_range(1, 3000)));
		write_reg(REG_GLOW_THRESHOLD, 16'($urandom));
		for (int i = 0; i < count; i++)
			send_bin(rand_cmd(), rand_part(), rand_part(), 8'($urandom));
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_len = 400;
		for (int i = 0; i < 30; i++)
			send_bin(rand_cmd(), rand_part(), rand_part(), 8'($urandom));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		send_idle_pct = 14;
		recv_idle_pct = 78;
		test_random(180);
		test_random(180);
		send_idle_pct = 78;
		recv_idle_pct = 14;
		test_random(180);
		test_random(180);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(180);
		test_random(180);
		test_backpressure();
		@(negedge clk);
		in_valid = 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("tb_spectrogram_bin_colour_map_unit OK");
		else
			$display("tb_spectrogram_bin_colour_map_unit NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sbcm_pkg.sv
rtl/sbcm_div.sv
rtl/sbcm_datapath.sv
rtl/sbcm_ctrl.sv
rtl/spectrogram_bin_colour_map_unit.sv
sim/tb_spectrogram_bin_colour_map_unit.sv
